### src/pwsrc_pkg.sv
// Shared types and constants for the pulse waveform source.
`default_nettype none
package pwsrc_pkg;

  localparam int unsigned TIME_BITS_DEF  = 32;
  localparam int unsigned LEVEL_BITS_DEF = 16;
  localparam int unsigned DUR_BITS       = 31;
  localparam int unsigned CFG_DATA_BITS  = 32;
  localparam int unsigned CFG_IDX_BITS   = 3;
  localparam int unsigned QUEUE_DEPTH    = 4;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_INITIAL_LEVEL = 3'd0,
    CFG_PEAK_LEVEL    = 3'd1,
    CFG_DELAY_TICKS   = 3'd2,
    CFG_RISE_TICKS    = 3'd3,
    CFG_WIDTH_TICKS   = 3'd4,
    CFG_FALL_TICKS    = 3'd5,
    CFG_PERIOD_TICKS  = 3'd6
  } cfg_reg_e;

  typedef enum logic [2:0] {
    SEG_ZERO = 3'd0,
    SEG_INIT = 3'd1,
    SEG_RISE = 3'd2,
    SEG_PEAK = 3'd3,
    SEG_FALL = 3'd4
  } seg_e;

  typedef struct packed {
    logic [DUR_BITS-1:0] delay;
    logic [DUR_BITS-1:0] rise;
    logic [DUR_BITS-1:0] width;
    logic [DUR_BITS-1:0] fall;
    logic [DUR_BITS-1:0] period;
  } dur_cfg_t;

  typedef struct packed {
    seg_e                seg;
    logic [DUR_BITS-1:0] elapsed;
  } item_t;

endpackage
`default_nettype wire

### src/pwsrc_front.sv
// Front end: time capture, period fold by a pipelined remainder, segment classification.
`default_nettype none
module pwsrc_front
  import pwsrc_pkg::*;
#(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [TIME_BITS-1:0] time_ticks_i,
  output logic                 stall_o,
  input  dur_cfg_t             dur_i,
  input  logic                 full_i,
  output logic                 push_o,
  output item_t                item_o
);

  localparam int unsigned UB = TIME_BITS - 1;
  localparam int unsigned CW = (TIME_BITS > 34) ? TIME_BITS : 34;

  logic                en;
  logic [UB+1:0]       v_q;
  logic                neg_q  [0:UB];
  logic                fold_q [0:UB];
  logic [UB-1:0]       tu_q   [0:UB];
  logic [UB-1:0]       u_q    [0:UB];
  logic [DUR_BITS-1:0] rem_q  [0:UB];
  logic [CW-1:0]       tf_q;
  logic                cneg_q;

  logic [CW-1:0] tu_w, d_w, p_w, dp_w, u_full, tf_d;
  logic [CW-1:0] e_rise, e_width, e_fall, el_rise, el_fall;

  assign en      = !full_i;
  assign stall_o = full_i;

  assign tu_w   = CW'(time_ticks_i[UB-1:0]);
  assign d_w    = CW'(dur_i.delay);
  assign p_w    = CW'(dur_i.period);
  assign dp_w   = d_w + p_w;
  assign u_full = tu_w - d_w - CW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[UB:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg_q[0]  <= time_ticks_i[TIME_BITS-1];
      fold_q[0] <= tu_w > dp_w;
      tu_q[0]   <= time_ticks_i[UB-1:0];
      u_q[0]    <= u_full[UB-1:0];
      rem_q[0]  <= '0;
    end
  end

  for (genvar g = 0; g < UB; g++) begin : g_step
    logic [DUR_BITS:0]   r2;
    logic [DUR_BITS+1:0] r2s;
    assign r2  = {rem_q[g], u_q[g][UB-1]};
    assign r2s = {1'b0, r2} - {2'b00, dur_i.period};
    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q[g+1]  <= r2s[DUR_BITS+1] ? r2[DUR_BITS-1:0] : r2s[DUR_BITS-1:0];
        u_q[g+1]    <= {u_q[g][UB-2:0], 1'b0};
        tu_q[g+1]   <= tu_q[g];
        neg_q[g+1]  <= neg_q[g];
        fold_q[g+1] <= fold_q[g];
      end
    end
  end

  assign tf_d = fold_q[UB] ? (d_w + CW'(1) + CW'(rem_q[UB])) : CW'(tu_q[UB]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      tf_q   <= tf_d;
      cneg_q <= neg_q[UB];
    end
  end

  assign e_rise  = d_w + CW'(dur_i.rise);
  assign e_width = e_rise + CW'(dur_i.width);
  assign e_fall  = e_width + CW'(dur_i.fall);
  assign el_rise = tf_q - d_w;
  assign el_fall = tf_q - e_width;

  always_comb begin
    item_o.elapsed = el_rise[DUR_BITS-1:0];
    if (cneg_q) begin
      item_o.seg = SEG_ZERO;
    end else if (tf_q <= d_w) begin
      item_o.seg = SEG_INIT;
    end else if (tf_q < e_rise) begin
      item_o.seg = SEG_RISE;
    end else if (tf_q <= e_width) begin
      item_o.seg = SEG_PEAK;
    end else if (tf_q < e_fall) begin
      item_o.seg     = SEG_FALL;
      item_o.elapsed = el_fall[DUR_BITS-1:0];
    end else if (tf_q <= dp_w) begin
      item_o.seg = SEG_INIT;
    end else begin
      item_o.seg = SEG_ZERO;
    end
  end

  assign push_o = en && v_q[UB+1];

endmodule
`default_nettype wire

### src/pwsrc_queue.sv
// Short FIFO of classified items between front and back.
`default_nettype none
module pwsrc_queue
  import pwsrc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t data_o
);

  localparam int unsigned PB = $clog2(QUEUE_DEPTH);

  item_t       mem_q [QUEUE_DEPTH];
  logic [PB-1:0] wr_q, rd_q;
  logic [PB:0]   cnt_q;

  assign full_o  = (cnt_q == (PB+1)'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + PB'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + PB'(1);
      end
      cnt_q <= cnt_q + (PB+1)'(push_i) - (PB+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

### src/pwsrc_back.sv
// Back end: ramp multiply, pipelined divide by ramp duration, level select, output register.
`default_nettype none
module pwsrc_back
  import pwsrc_pkg::*;
#(
  parameter int unsigned LEVEL_BITS = LEVEL_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  item_t                 item_i,
  output logic                  pop_o,
  input  logic [LEVEL_BITS-1:0] initial_level_i,
  input  logic [LEVEL_BITS-1:0] peak_level_i,
  input  dur_cfg_t              dur_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [LEVEL_BITS-1:0] level_o
);

  localparam int unsigned L  = LEVEL_BITS;
  localparam int unsigned PW = L + DUR_BITS;

  logic                en;
  logic [L+1:0]        v_q;
  item_t               b0_q;
  seg_e                seg_q [0:L];
  logic [DUR_BITS-1:0] r_q   [0:L];
  logic [L-1:0]        lo_q  [0:L];
  logic [L-1:0]        qt_q  [0:L];
  logic                ov_q;
  logic [L-1:0]        level_q;

  logic [L:0]    diff, dmag, init_x, peak_x, q_x, sum;
  logic          dneg;
  logic [PW-1:0] prod;

  assign en    = !ov_q || !out_stall_i;
  assign pop_o = en && q_valid_i;

  assign init_x = {initial_level_i[L-1], initial_level_i};
  assign peak_x = {peak_level_i[L-1], peak_level_i};
  assign diff   = peak_x - init_x;
  assign dneg   = diff[L];
  assign dmag   = dneg ? (~diff + (L+1)'(1)) : diff;
  assign prod   = PW'(dmag[L-1:0]) * PW'(b0_q.elapsed);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= '0;
      ov_q <= 1'b0;
    end else if (en) begin
      v_q  <= {v_q[L:0], q_valid_i};
      ov_q <= v_q[L+1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b0_q     <= item_i;
      seg_q[0] <= b0_q.seg;
      r_q[0]   <= prod[PW-1:L];
      lo_q[0]  <= prod[L-1:0];
      qt_q[0]  <= '0;
    end
  end

  for (genvar g = 0; g < L; g++) begin : g_div
    logic [DUR_BITS-1:0] dur;
    logic [DUR_BITS:0]   r2;
    logic [DUR_BITS+1:0] r2s;
    assign dur = (seg_q[g] == SEG_RISE) ? dur_i.rise : dur_i.fall;
    assign r2  = {r_q[g], lo_q[g][L-1]};
    assign r2s = {1'b0, r2} - {2'b00, dur};
    always_ff @(posedge clk_i) begin
      if (en) begin
        r_q[g+1]   <= r2s[DUR_BITS+1] ? r2[DUR_BITS-1:0] : r2s[DUR_BITS-1:0];
        lo_q[g+1]  <= {lo_q[g][L-2:0], 1'b0};
        qt_q[g+1]  <= {qt_q[g][L-2:0], ~r2s[DUR_BITS+1]};
        seg_q[g+1] <= seg_q[g];
      end
    end
  end

  assign q_x = {1'b0, qt_q[L]};

  always_comb begin
    case (seg_q[L])
      SEG_INIT: sum = init_x;
      SEG_PEAK: sum = peak_x;
      SEG_RISE: sum = dneg ? (init_x - q_x) : (init_x + q_x);
      SEG_FALL: sum = dneg ? (peak_x + q_x) : (peak_x - q_x);
      default:  sum = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      level_q <= sum[L-1:0];
    end
  end

  assign out_valid_o = ov_q;
  assign level_o     = level_q;

endmodule
`default_nettype wire

### src/pulse_waveform_source.sv
// Periodic trapezoid pulse source: one time value in, one waveform level out.
//
// Input channel: in_valid_i / in_stall_o with time_ticks_i; a transfer happens
// at a clock edge with in_valid_i high and in_stall_o low. Output channel:
// out_valid_o / out_stall_i with level_o, same rule. Registers are written
// through cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i; write
// them only while no item is in flight.
// From input to output transfer an item passes one stage per time bit for
// capture and the remainder pipeline that folds the time into one period,
// one stage per level bit in the divider that scales the ramp, plus
// classify, queue, queue read, multiply and output.
// Throughput is one item per cycle while in_stall_o and out_stall_i are low.
// A stalled output holds the back pipeline; the front keeps taking items
// until the four-entry queue between them fills, then raises in_stall_o.
// Reset empties all stages and sets every register to 0 except the period,
// which resets to 1.
`default_nettype none
module pulse_waveform_source
  import pwsrc_pkg::*;
#(
  parameter int unsigned TIME_BITS  = TIME_BITS_DEF,
  parameter int unsigned LEVEL_BITS = LEVEL_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [TIME_BITS-1:0]     time_ticks_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [LEVEL_BITS-1:0]    level_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  logic [LEVEL_BITS-1:0] init_q, peak_q;
  logic [DUR_BITS-1:0]   delay_q, rise_q, width_q, fall_q, period_q;
  dur_cfg_t              dur;
  logic                  q_full, q_push, q_pop, q_valid;
  item_t                 q_wdata, q_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q   <= '0;
      peak_q   <= '0;
      delay_q  <= '0;
      rise_q   <= '0;
      width_q  <= '0;
      fall_q   <= '0;
      period_q <= DUR_BITS'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_INITIAL_LEVEL: init_q   <= cfg_data_i[LEVEL_BITS-1:0];
        CFG_PEAK_LEVEL:    peak_q   <= cfg_data_i[LEVEL_BITS-1:0];
        CFG_DELAY_TICKS:   delay_q  <= cfg_data_i[DUR_BITS-1:0];
        CFG_RISE_TICKS:    rise_q   <= cfg_data_i[DUR_BITS-1:0];
        CFG_WIDTH_TICKS:   width_q  <= cfg_data_i[DUR_BITS-1:0];
        CFG_FALL_TICKS:    fall_q   <= cfg_data_i[DUR_BITS-1:0];
        CFG_PERIOD_TICKS:  period_q <= cfg_data_i[DUR_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    dur.delay  = delay_q;
    dur.rise   = rise_q;
    dur.width  = width_q;
    dur.fall   = fall_q;
    dur.period = (period_q == '0) ? DUR_BITS'(1) : period_q;
  end

  pwsrc_front #(.TIME_BITS(TIME_BITS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .time_ticks_i (time_ticks_i),
    .stall_o      (in_stall_o),
    .dur_i        (dur),
    .full_i       (q_full),
    .push_o       (q_push),
    .item_o       (q_wdata)
  );

  pwsrc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  pwsrc_back #(.LEVEL_BITS(LEVEL_BITS)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .item_i          (q_rdata),
    .pop_o           (q_pop),
    .initial_level_i (init_q),
    .peak_level_i    (peak_q),
    .dur_i           (dur),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .level_o         (level_o)
  );

endmodule
`default_nettype wire

### src/pwsrc_checker.sv
// Port-level assertions for the pulse waveform source, bound to the top level.
`default_nettype none
module pwsrc_checker
  import pwsrc_pkg::*;
#(
  parameter int unsigned TIME_BITS  = TIME_BITS_DEF,
  parameter int unsigned LEVEL_BITS = LEVEL_BITS_DEF
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [LEVEL_BITS-1:0] level_o
);

  localparam int unsigned MaxInFlight = TIME_BITS + LEVEL_BITS + QUEUE_DEPTH + 4;
  localparam int unsigned CB = $clog2(MaxInFlight + 1) + 1;

  logic [CB-1:0] cnt_q;
  logic          acc, del;

  assign acc = in_valid_i && !in_stall_o;
  assign del = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + CB'(acc) - CB'(del);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(level_o))
    else $error("stalled result changed or dropped");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cnt_q != '0)
    else $error("result without an outstanding item");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CB'(MaxInFlight))
    else $error("more items in flight than the pipeline holds");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> cnt_q >= CB'(QUEUE_DEPTH))
    else $error("input stalled with queue not full");

endmodule

bind pulse_waveform_source pwsrc_checker #(
  .TIME_BITS  (TIME_BITS),
  .LEVEL_BITS (LEVEL_BITS)
) u_pwsrc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .level_o     (level_o)
);
`default_nettype wire

### tb/pulse_waveform_source_checker.sv
// Checker for the pulse waveform source: predicts each level and compares transfers.
module pulse_waveform_source_checker
  import pwsrc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic [31:0]              time_ticks_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic [15:0]              level_i,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  output int                       fail_count_o,
  output int                       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [15:0] init_lvl, peak_lvl;
  logic [30:0] delay_t, rise_t, width_t, fall_t, period_t;
  logic [15:0] level_q[$];

  function automatic longint scale(longint diff, longint elapsed, longint dur);
    longint mag;
    longint q;
    mag = diff < 0 ? -diff : diff;
    q = (mag * elapsed) / dur;
    return diff < 0 ? -q : q;
  endfunction

  function automatic logic [15:0] pulse_level(logic signed [31:0] tin);
    longint t, d, p, er, ew, ef, diff, lvl, k;
    t = tin;
    d = delay_t;
    p = (period_t == 0) ? 1 : period_t;
    er = d + rise_t;
    ew = er + width_t;
    ef = ew + fall_t;
    diff = longint'(peak_lvl) - longint'(init_lvl);
    lvl = 0;
    if (t >= 0) begin
      if (t > d + p) begin
        k = (t - d - 1) / p;
        t -= k * p;
      end
      if (t <= d) lvl = init_lvl;
      else if (t < er) lvl = init_lvl + scale(diff, t - d, rise_t);
      else if (t <= ew) lvl = peak_lvl;
      else if (t < ef) lvl = peak_lvl - scale(diff, t - ew, fall_t);
      else if (t <= d + p) lvl = init_lvl;
      else lvl = 0;
    end
    return lvl[15:0];
  endfunction

  assign pending_o = level_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    logic [15:0] want;
    if (!rst_ni) begin
      init_lvl <= '0; peak_lvl <= '0; delay_t <= '0; rise_t <= '0;
      width_t <= '0; fall_t <= '0; period_t <= 31'd1;
      fail_count_o <= 0;
      level_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_INITIAL_LEVEL: init_lvl <= cfg_data_i[15:0];
          CFG_PEAK_LEVEL:    peak_lvl <= cfg_data_i[15:0];
          CFG_DELAY_TICKS:   delay_t <= cfg_data_i[30:0];
          CFG_RISE_TICKS:    rise_t <= cfg_data_i[30:0];
          CFG_WIDTH_TICKS:   width_t <= cfg_data_i[30:0];
          CFG_FALL_TICKS:    fall_t <= cfg_data_i[30:0];
          CFG_PERIOD_TICKS:  period_t <= cfg_data_i[30:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) level_q.push_back(pulse_level(time_ticks_i));
      if (out_valid_i && !out_stall_i) begin
        if (level_q.size() == 0) begin
          $display("%0t: unexpected level transfer, actual %0d", $time, $signed(level_i));
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = level_q.pop_front();
          if (want !== level_i) begin
            $display("%0t: level mismatch, expected %0d actual %0d", $time,
                     $signed(want), $signed(level_i));
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

### tb/pulse_waveform_source_test.sv
// Top of the pulse waveform source test: clock, reset, stimulus and verdict.
module pulse_waveform_source_test;
  import pwsrc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [31:0] time_ticks_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [15:0] level_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data_i = '0;
  int fail_count, pending;
  int cycle_count = 0;
  int phase = 0;
  bit calm = 1'b0;
  bit hold_off = 1'b0;
  logic [30:0] cur_period = 31'd1, cur_delay = '0;

  pulse_waveform_source u_top (.*);

  pulse_waveform_source_checker u_check (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .time_ticks_i,
    .out_valid_i(out_valid_o), .out_stall_i, .level_i(level_o), .cfg_valid_i,
    .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial forever #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("pulse_waveform_source_test: FAIL");
      $finish;
    end
  end

  // receiver stalls: random, calm stretch, and one long hold-off
  always @(negedge clk_i) begin
    if (hold_off) out_stall_i <= 1'b1;
    else if (calm) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(99) < 10);
  end

  initial begin
    wait (phase == 2);
    @(negedge clk_i);
    hold_off = 1'b1;
    repeat (200) @(negedge clk_i);
    hold_off = 1'b0;
  end

  task automatic write_reg(cfg_reg_e idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_time(logic [31:0] t);
    while (!calm && $urandom_range(99) < 10) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    time_ticks_i <= t;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic set_wave(logic [31:0] il, logic [31:0] pl, logic [31:0] d, logic [31:0] r,
                          logic [31:0] w, logic [31:0] f, logic [31:0] p);
    write_reg(CFG_INITIAL_LEVEL, il);
    write_reg(CFG_PEAK_LEVEL, pl);
    write_reg(CFG_DELAY_TICKS, d);
    write_reg(CFG_RISE_TICKS, r);
    write_reg(CFG_WIDTH_TICKS, w);
    write_reg(CFG_FALL_TICKS, f);
    write_reg(CFG_PERIOD_TICKS, p);
    cur_delay = d[30:0];
    cur_period = p[30:0];
  endtask

  // times spread over the first periods after the delay of the current waveform, plus random ones
  function automatic logic [31:0] pick_time();
    longint base, span;
    span = (cur_period == 0) ? 1 : cur_period;
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(64);
      default: begin
        base = cur_delay + longint'($urandom_range(4)) * span;
        base = base + ($urandom() % (span + 2)) - 1;
        if (base > 32'h7fff_ffff) base = $urandom() & 32'h7fff_ffff;
        if (base < 0) base = 0;
        return base[31:0];
      end
    endcase
  endfunction

  initial begin
    logic [31:0] edge_times[12];
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // reset defaults
    send_time(32'd0);
    send_time(32'd5);
    drain();
    set_wave(32'hffff_8000, 32'h0000_7fff, 10, 4, 3, 5, 30);
    edge_times = '{32'h8000_0000, 32'hffff_ffff, 0, 10, 11, 13, 14, 17, 18, 22, 40,
                   32'h7fff_ffff};
    foreach (edge_times[i]) send_time(edge_times[i]);
    drain();
    // instant steps, zero period, overlong pulse, masked high bits
    set_wave(32'h1234_7fff, 32'hffff_8000, 32'hffff_ffff, 0, 0, 0, 0);
    send_time(32'h7fff_ffff);
    send_time(32'h7fff_fffe);
    drain();
    set_wave(100, 32'hffff_ff00, 2, 7, 9, 8, 10);
    for (int i = 0; i < 8; i++) send_time(i * 3);
    drain();
    set_wave(32'h7fff, 32'hffff_8000, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
             32'h7fff_ffff);
    send_time(32'h7fff_ffff);
    send_time(32'h4000_0000);
    drain();
    phase = 1;
    for (int s = 0; s < 10; s++) begin
      calm = (s == 3);
      if (s % 3 == 0)
        set_wave($urandom(), $urandom(), $urandom_range(40), $urandom_range(20),
                 $urandom_range(20), $urandom_range(20), $urandom_range(100));
      else
        set_wave($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom());
      if (s == 5) phase = 2;
      for (int i = 0; i < 100; i++) send_time(pick_time());
      drain();
    end
    calm = 1'b0;
    if (fail_count == 0) $display("pulse_waveform_source_test: PASS");
    else $display("pulse_waveform_source_test: FAIL");
    $finish;
  end
endmodule
